// ----- hdl/response_frame_receiver_macros.svh -----
// Assertion macros for the response frame receiver
`ifndef RESPONSE_FRAME_RECEIVER_MACROS_SVH
`define RESPONSE_FRAME_RECEIVER_MACROS_SVH

// Implication checked at every clock edge outside reset
`define RFR_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Condition that must never hold outside reset
`define RFR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hdl/rfr_pkg.sv -----
// Shared constants and the CRC-16 byte update for the response frame receiver
package rfr_pkg;

	// framing characters
	localparam logic [7:0] START_BYTE = 8'h2F;
	localparam logic [7:0] END_BYTE   = 8'h0A;

	// CRC-16, polynomial 0x1021, MSB first
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// default payload bound and register reset value
	localparam int         MAX_PAYLOAD_DEF = 32;
	localparam logic [7:0] ESTOP_MASK_RST  = 8'h01;

	// length byte width and the width used for position/length compares
	localparam int LEN_W = 8;
	localparam int CMP_W = LEN_W + 1;

	// capture windows within the frame
	localparam int HDR_FIRST = 2;
	localparam int HDR_BYTES = 4;
	localparam int PAY_FIRST = 6;
	localparam int PAY_BYTES = 8;

	// status byte field holding the control mode
	localparam int         MODE_LSB  = 1;
	localparam logic [1:0] MODE_MASK = 2'h3;

	// one byte through the CRC, eight shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- hdl/response_frame_receiver.sv -----
// Framed response receiver: byte stream in, one decoded result word per frame out
//
// Input channel: in_valid / in_stall with rx_byte, one received byte per word.
// Output channel: out_valid / out_stall with the decoded fields of one frame.
// Configuration: cfg_wr_en writes cfg_wr_data into the e-stop mask (reset 0x01).
// A frame opens on '/', byte 1 gives the payload length L, and the frame is
// L+8 bytes long; its last byte, the trailing '\n' slot, gives its result.
// Frames with L above MAX_PAYLOAD are dropped without a result.
// Throughput: one byte per cycle while the output is not stalled; the CRC-16
// byte update and the capture sit between the input register and the
// state/result registers. A byte in the input register is processed into the
// state registers, and the result of a frame is registered when its last byte
// is processed, both only while the output has room.
// Reset (arst_n low) returns the receiver to hunting and empties both stages.
// When the receiver stalls a held result, the input register fills and
// in_stall rises in the same cycle; the result holds until taken.
`include "response_frame_receiver_macros.svh"

module response_frame_receiver #(
	parameter int MAX_PAYLOAD = rfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// frame result
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [7:0]  sequence_byte,
	output logic [7:0]  command_code,
	output logic [7:0]  response_code,
	output logic [7:0]  status_byte,
	output logic        estop_flag,
	output logic [1:0]  control_mode,
	output logic [31:0] payload_low_word,
	output logic [31:0] payload_high_word,
	output logic [5:0]  payload_length
);

	localparam int POS_W = $clog2(MAX_PAYLOAD + 8);
	localparam int LEN_W = rfr_pkg::LEN_W;
	localparam int CMP_W = rfr_pkg::CMP_W;
	localparam int HDR_W = 8 * rfr_pkg::HDR_BYTES;
	localparam int PAY_W = 8 * rfr_pkg::PAY_BYTES;

	// configuration register
	logic [7:0] estop_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			estop_mask_q <= rfr_pkg::ESTOP_MASK_RST;
		else if (cfg_wr_en)
			estop_mask_q <= cfg_wr_data;
	end

	// handshake control
	logic s1_valid;
	logic [7:0] byte_s1;
	logic out_valid_q;
	logic out_room;
	logic consume;
	logic accept;

	assign out_room = !out_valid_q || !out_stall;
	assign consume  = s1_valid && out_room;
	assign in_stall = s1_valid && !out_room;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (accept)
			s1_valid <= 1'b1;
		else if (consume)
			s1_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= rx_byte;
	end

	// frame state
	logic             collecting_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      crc_q;
	logic [HDR_W-1:0] hdr_q;
	logic [PAY_W-1:0] pay_q;
	logic [7:0]       crc_lo_q;

	// next-state signals
	logic             frame_on;
	logic             start;
	logic [POS_W-1:0] p;
	logic [LEN_W-1:0] len_d;
	logic [15:0]      crc_cur;
	logic [15:0]      crc_d;
	logic [HDR_W-1:0] hdr_d;
	logic [PAY_W-1:0] pay_d;
	logic [7:0]       crc_lo_cur;
	logic [7:0]       crc_lo_d;
	logic [CMP_W-1:0] p_ext;
	logic [CMP_W-1:0] len_ext;
	logic             drop;
	logic             last;
	logic             coll_d;
	logic [POS_W-1:0] pos_d;
	logic             update;

	// per-byte decode: captures, CRC and frame end
	always_comb begin
		start      = !collecting_q;
		frame_on   = collecting_q || (byte_s1 == rfr_pkg::START_BYTE);
		p          = start ? '0 : pos_q;
		len_d      = start ? '0 : len_q;
		crc_cur    = start ? '0 : crc_q;
		hdr_d      = start ? '0 : hdr_q;
		pay_d      = start ? '0 : pay_q;
		crc_lo_cur = start ? '0 : crc_lo_q;
		crc_lo_d   = crc_lo_cur;
		crc_d      = crc_cur;
		drop       = 1'b0;
		last       = 1'b0;

		// length byte and oversize check
		if (p == POS_W'(1)) begin
			len_d = byte_s1;
			drop  = ({1'b0, byte_s1} > CMP_W'(MAX_PAYLOAD));
		end

		// header and payload byte slots
		for (int i = 0; i < rfr_pkg::HDR_BYTES; i++) begin
			if (p == POS_W'(rfr_pkg::HDR_FIRST + i))
				hdr_d[8*i +: 8] = byte_s1;
		end
		for (int i = 0; i < rfr_pkg::PAY_BYTES; i++) begin
			if (p == POS_W'(rfr_pkg::PAY_FIRST + i))
				pay_d[8*i +: 8] = byte_s1;
		end

		// CRC body, CRC bytes, terminator
		p_ext   = CMP_W'(p);
		len_ext = {1'b0, len_d};
		if (p_ext <= len_ext + CMP_W'(4))
			crc_d = rfr_pkg::crc16_byte(crc_cur, byte_s1);
		else if (p_ext == len_ext + CMP_W'(5))
			crc_lo_d = byte_s1;
		else if (p_ext == len_ext + CMP_W'(6))
			crc_d = crc_cur ^ {byte_s1, crc_lo_cur};
		else
			last = 1'b1;

		coll_d = !(drop || last);
		pos_d  = coll_d ? p + POS_W'(1) : '0;
	end

	assign update = consume && frame_on;

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= '0;
		end else if (update) begin
			collecting_q <= coll_d;
			pos_q        <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			len_q    <= len_d;
			crc_q    <= crc_d;
			hdr_q    <= hdr_d;
			pay_q    <= pay_d;
			crc_lo_q <= crc_lo_d;
		end
	end

	// result register
	logic out_load;
	logic [7:0] status_d;

	assign out_load = update && last;
	assign status_d = hdr_d[24 +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			frame_ok          <= (crc_cur == 16'h0000) && (byte_s1 == rfr_pkg::END_BYTE);
			sequence_byte     <= hdr_d[0 +: 8];
			command_code      <= hdr_d[8 +: 8];
			response_code     <= hdr_d[16 +: 8];
			status_byte       <= status_d;
			estop_flag        <= ((status_d & estop_mask_q) == estop_mask_q);
			control_mode      <= status_d[rfr_pkg::MODE_LSB +: 2] & rfr_pkg::MODE_MASK;
			payload_low_word  <= pay_d[0 +: 32];
			payload_high_word <= pay_d[32 +: 32];
			payload_length    <= len_d[5:0];
		end
	end

	assign out_valid = out_valid_q;

	// checks on the frame tracking
	`RFR_ASSERT_IMPL(a_pos_in_frame, collecting_q,
		CMP_W'(pos_q) <= {1'b0, len_q} + CMP_W'(7), "byte position beyond frame end")
	`RFR_ASSERT_IMPL(a_pos_idle, !collecting_q, pos_q == '0, "position not cleared while hunting")
	`RFR_ASSERT_IMPL(a_len_bound, collecting_q && (pos_q >= POS_W'(2)),
		{1'b0, len_q} <= CMP_W'(MAX_PAYLOAD), "oversized frame kept")
	`RFR_ASSERT_NEVER(a_result_outside, out_load && !collecting_q, "result without an open frame")

endmodule

// ----- bench/tb_response_frame_receiver.sv -----
// Self-checking bench for the response frame receiver: framed byte traffic against a frame decoder
`timescale 1ns / 100ps

module tb_response_frame_receiver;

	localparam int PAYLOAD_BOUND = rfr_pkg::MAX_PAYLOAD_DEF;
	// a byte is processed from the input register, and its result registered, once the output has room
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 300;

	// decoded contents of one frame
	typedef struct {
		logic        ok;
		logic [7:0]  seq;
		logic [7:0]  cmd;
		logic [7:0]  resp;
		logic [7:0]  status;
		logic        estop;
		logic [1:0]  mode;
		logic [31:0] pay_lo;
		logic [31:0] pay_hi;
		logic [5:0]  len;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_ok;
	logic [7:0]  sequence_byte;
	logic [7:0]  command_code;
	logic [7:0]  response_code;
	logic [7:0]  status_byte;
	logic        estop_flag;
	logic [1:0]  control_mode;
	logic [31:0] payload_low_word;
	logic [31:0] payload_high_word;
	logic [5:0]  payload_length;

	response_frame_receiver dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_ok         (frame_ok),
		.sequence_byte    (sequence_byte),
		.command_code     (command_code),
		.response_code    (response_code),
		.status_byte      (status_byte),
		.estop_flag       (estop_flag),
		.control_mode     (control_mode),
		.payload_low_word (payload_low_word),
		.payload_high_word(payload_high_word),
		.payload_length   (payload_length)
	);

	always #6 clk = ~clk;

	logic [7:0] byte_queue [$];
	frame_t     frames_due [$];
	int         mismatches = 0;

	// decoder state, mirrors the receiver
	logic [7:0]  mask_now = rfr_pkg::ESTOP_MASK_RST;
	bit          rx_collecting = 1'b0;
	int          rx_pos = 0;
	int          rx_len = 0;
	logic [15:0] rx_crc = 16'h0000;
	logic [31:0] rx_hdr = 32'h0;
	logic [63:0] rx_pay = 64'h0;
	logic [7:0]  rx_crc_lo = 8'h00;

	// bit-serial CRC-16, MSB first
	function automatic logic [15:0] crc_shift_in(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			if (c[15] ^ b[k])
				c = {c[14:0], 1'b0} ^ rfr_pkg::CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// advance the decoder by one accepted byte; queue a frame result at frame end
	task automatic decode_byte(input logic [7:0] b);
		frame_t f;
		int     p;
		if (!rx_collecting) begin
			if (b != rfr_pkg::START_BYTE)
				return;
			rx_collecting = 1'b1;
			rx_pos = 0;
			rx_len = 0;
			rx_crc = 16'h0000;
			rx_hdr = 32'h0;
			rx_pay = 64'h0;
			rx_crc_lo = 8'h00;
		end
		p = rx_pos;
		if (p == 1) begin
			rx_len = int'(b);
			// oversized length: drop, length byte not re-examined
			if (b > PAYLOAD_BOUND) begin
				rx_collecting = 1'b0;
				rx_pos = 0;
				return;
			end
		end
		if (p >= 2 && p <= 5)
			rx_hdr[(p - 2) * 8 +: 8] = b;
		if (p >= 6 && p <= 13)
			rx_pay[(p - 6) * 8 +: 8] = b;
		if (p <= rx_len + 4)
			rx_crc = crc_shift_in(rx_crc, b);
		else if (p == rx_len + 5)
			rx_crc_lo = b;
		else if (p == rx_len + 6)
			rx_crc = rx_crc ^ {b, rx_crc_lo};
		else begin
			f.ok     = (rx_crc == 16'h0000) && (b == rfr_pkg::END_BYTE);
			f.seq    = rx_hdr[7:0];
			f.cmd    = rx_hdr[15:8];
			f.resp   = rx_hdr[23:16];
			f.status = rx_hdr[31:24];
			f.estop  = (rx_hdr[31:24] & mask_now) == mask_now;
			f.mode   = rx_hdr[26:25];
			f.pay_lo = rx_pay[31:0];
			f.pay_hi = rx_pay[63:32];
			f.len    = rx_len[5:0];
			frames_due.push_back(f);
			rx_collecting = 1'b0;
			rx_pos = 0;
			return;
		end
		rx_pos = p + 1;
	endtask

	// frame with random content; cut < 0 keeps it whole, else only the first cut bytes
	function automatic int push_frame(input int len, input bit bad_crc, input bit bad_term,
			input int cut);
		logic [7:0]  fb [$];
		logic [15:0] crc;
		logic [7:0]  term;
		int          n;
		fb.push_back(rfr_pkg::START_BYTE);
		fb.push_back(len[7:0]);
		for (int i = 2; i <= len + 4; i++) begin
			// status byte often all ones so wide masks still see e-stop
			if (i == 5 && $urandom_range(3) == 0)
				fb.push_back(8'hFF);
			else
				fb.push_back(8'($urandom_range(255)));
		end
		crc = 16'h0000;
		foreach (fb[i])
			crc = crc_shift_in(crc, fb[i]);
		if (bad_crc)
			crc = crc ^ (16'h0001 << $urandom_range(15));
		fb.push_back(crc[7:0]);
		fb.push_back(crc[15:8]);
		term = rfr_pkg::END_BYTE;
		if (bad_term) begin
			term = 8'($urandom_range(255));
			if (term == rfr_pkg::END_BYTE)
				term = term ^ 8'h01;
		end
		fb.push_back(term);
		n = (cut < 0 || cut > fb.size()) ? fb.size() : cut;
		for (int i = 0; i < n; i++)
			byte_queue.push_back(fb[i]);
		return n;
	endfunction

	// mostly well-formed frames, some broken ones and line noise
	function automatic int push_traffic(input int n_bytes);
		int added;
		int r;
		int len;
		added = 0;
		while (added < n_bytes) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(13);
			else if (r < 92)
				len = $urandom_range(31, 14);
			else
				len = PAYLOAD_BOUND;
			r = $urandom_range(99);
			if (r < 70)
				added += push_frame(len, 1'b0, 1'b0, -1);
			else if (r < 80)
				added += push_frame(len, 1'b1, 1'b0, -1);
			else if (r < 86)
				added += push_frame(len, 1'b0, 1'b1, -1);
			else if (r < 92)
				added += push_frame(len, 1'b0, 1'b0, $urandom_range(len + 6, 1));
			else begin
				// oversized length
				byte_queue.push_back(rfr_pkg::START_BYTE);
				byte_queue.push_back(8'($urandom_range(255, PAYLOAD_BOUND + 1)));
				added += 2;
			end
			// noise between frames, rarely a stray start byte
			if ($urandom_range(99) < 30) begin
				repeat ($urandom_range(3, 1)) begin
					byte_queue.push_back(8'($urandom_range(255)));
					added++;
				end
			end
		end
		return added;
	endfunction

	// wait for the pipeline to empty: all bytes sent, all frames seen, drain
	task automatic wait_idle;
		while (byte_queue.size() != 0 || in_valid)
			@(negedge clk);
		while (frames_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mask(input logic [7:0] v);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		mask_now = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
		end
	endtask

	// sender: one word per accepted byte, random gaps, a gap-free stretch
	int bytes_taken = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(rx_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (byte_queue.size() != 0 &&
						((bytes_taken >= 450 && bytes_taken < 700) || $urandom_range(99) >= 6)) begin
					in_valid <= 1'b1;
					rx_byte <= byte_queue.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver: compare each result word, one long hold-off, random stalls, a stall-free stretch
	int     results_seen = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	frame_t want_frame;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					mismatches++;
					$display("%0t: result word with no frame pending, frame_ok %b", $time, frame_ok);
				end else begin
					want_frame = frames_due.pop_front();
					check_field("frame_ok", 32'(want_frame.ok), 32'(frame_ok));
					check_field("sequence_byte", 32'(want_frame.seq), 32'(sequence_byte));
					check_field("command_code", 32'(want_frame.cmd), 32'(command_code));
					check_field("response_code", 32'(want_frame.resp), 32'(response_code));
					check_field("status_byte", 32'(want_frame.status), 32'(status_byte));
					check_field("estop_flag", 32'(want_frame.estop), 32'(estop_flag));
					check_field("control_mode", 32'(want_frame.mode), 32'(control_mode));
					check_field("payload_low_word", want_frame.pay_lo, payload_low_word);
					check_field("payload_high_word", want_frame.pay_hi, payload_high_word);
					check_field("payload_length", 32'(want_frame.len), 32'(payload_length));
				end
				results_seen++;
				if (results_seen == 8 && !hold_done) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= 30 && results_seen < 45)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 6);
		end
	end

	// stimulus and end of run
	int pushed;

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames under the reset mask
		pushed = push_frame(0, 1'b0, 1'b0, -1);
		byte_queue.push_back(8'h00);
		byte_queue.push_back(8'hFF);
		// length one above the bound, then the largest length
		byte_queue.push_back(rfr_pkg::START_BYTE);
		byte_queue.push_back(8'(PAYLOAD_BOUND + 1));
		byte_queue.push_back(rfr_pkg::START_BYTE);
		byte_queue.push_back(8'hFF);
		// length byte equal to the start character must not restart the hunt
		byte_queue.push_back(rfr_pkg::START_BYTE);
		byte_queue.push_back(rfr_pkg::START_BYTE);
		pushed = push_frame(2, 1'b0, 1'b0, -1);
		pushed = push_frame(1, 1'b1, 1'b0, -1);
		pushed = push_frame(8, 1'b0, 1'b1, -1);

		write_mask(8'h00);
		pushed = push_traffic(320);
		write_mask(8'hFF);
		pushed = push_traffic(150);
		write_mask(8'($urandom_range(255)));
		pushed = push_traffic(150);
		write_mask(8'h06);
		pushed = push_traffic(170);

		wait_idle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
